// ===== hw/rtl/sqt_pkg.sv =====
package sqt_pkg;

    localparam int CoordW = 24;
    localparam int DimW   = 12;
    localparam int ScaleW = 16;
    localparam int AngW   = 16;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd1;

    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [15:0] SIN_B = 16'd42048;
    localparam logic [12:0] SIN_C = 13'd4640;
    localparam logic [AngW-1:0] QUARTER_TURN = 16'd16384;

    localparam logic signed [39:0] COORD_MAX = 40'sd8388607;
    localparam logic signed [39:0] COORD_MIN = -40'sd8388608;

    typedef struct packed {
        logic signed [CoordW-1:0] center_x;
        logic signed [CoordW-1:0] center_y;
        logic [AngW-1:0]          angle;
        logic [ScaleW-1:0]        uniform_scale;
        logic [ScaleW-1:0]        scale_x;
        logic [ScaleW-1:0]        scale_y;
    } sqt_in_t;

    typedef struct packed {
        logic signed [CoordW-1:0] corner0_x;
        logic signed [CoordW-1:0] corner0_y;
        logic signed [CoordW-1:0] corner1_x;
        logic signed [CoordW-1:0] corner1_y;
        logic signed [CoordW-1:0] corner2_x;
        logic signed [CoordW-1:0] corner2_y;
        logic signed [CoordW-1:0] corner3_x;
        logic signed [CoordW-1:0] corner3_y;
        logic signed [CoordW-1:0] box_left;
        logic signed [CoordW-1:0] box_top;
        logic signed [CoordW-1:0] box_right;
        logic signed [CoordW-1:0] box_bottom;
    } sqt_out_t;

endpackage

// ===== hw/rtl/sprite_quad_transform.sv =====
// channel   | signals                       | timing
// ----------+-------------------------------+---------------------------------
// input     | start, busy, sprite           | taken when start & !busy
// result    | done, quad                    | one cycle per taken word
// config    | cfg_we, cfg_index, cfg_data   | written on any edge with cfg_we
//
// Eight-stage pipeline: one word in per cycle, one word out per cycle.
// Latency is set by the four multiplies of the sine polynomial, then product,
// rounding, saturation and box stages. busy is always low.
// Reset clears the valid bits and both size registers.
// Results cannot be held off; each stays on quad for its done cycle only.
module sprite_quad_transform (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  sqt_pkg::sqt_in_t                    sprite,
    output logic                                done,
    output sqt_pkg::sqt_out_t                   quad,
    input  logic                                cfg_we,
    input  logic [sqt_pkg::CfgIdxW-1:0]         cfg_index,
    input  logic [sqt_pkg::DimW-1:0]            cfg_data
);

    logic [sqt_pkg::DimW-1:0] width_reg, width_next;
    logic [sqt_pkg::DimW-1:0] height_reg, height_next;
    logic [7:0] v_reg, v_next;

    logic signed [15:0] sin_w, cos_w;

    logic signed [23:0] cx_reg [1:7];
    logic signed [23:0] cy_reg [1:7];
    logic [15:0] sx1_reg, sy1_reg;
    logic [27:0] pw1_reg, ph1_reg;
    logic [34:0] hw_reg [2:4];
    logic [34:0] hh_reg [2:4];
    logic signed [51:0] p_hwc_reg, p_hhs_reg, p_hws_reg, p_hhc_reg;
    logic signed [38:0] rx6_reg [4];
    logic signed [38:0] ry6_reg [4];
    logic signed [23:0] px7_reg [4];
    logic signed [23:0] py7_reg [4];
    sqt_pkg::sqt_out_t  quad_reg, quad_next;

    logic [44:0] hw_sum, hh_sum;
    logic signed [38:0] rx_c [4];
    logic signed [38:0] ry_c [4];
    logic signed [23:0] px_c [4];
    logic signed [23:0] py_c [4];

    assign busy = 1'b0;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                sqt_pkg::CFG_WIDTH:  width_next  = cfg_data;
                sqt_pkg::CFG_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    assign v_next = {v_reg[6:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            v_reg      <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            v_reg      <= v_next;
        end
    end

    sqt_sine u_sine (
        .clk     (clk),
        .angle   (sprite.angle),
        .sin_q14 (sin_w),
        .cos_q14 (cos_w)
    );

    assign hw_sum = 45'(pw1_reg * sx1_reg) + 45'd256;
    assign hh_sum = 45'(ph1_reg * sy1_reg) + 45'd256;

    always_comb
    begin
        logic signed [52:0] a, b, c, d, xv, yv;
        logic signed [39:0] tx, ty;
        a = 53'(p_hwc_reg);
        b = 53'(p_hhs_reg);
        c = 53'(p_hws_reg);
        d = 53'(p_hhc_reg);
        for (int k = 0; k < 4; k++)
        begin
            xv = ((k & 2) != 0 ? a : -a) - ((k & 1) != 0 ? b : -b) + 53'sd8192;
            yv = ((k & 2) != 0 ? c : -c) + ((k & 1) != 0 ? d : -d) + 53'sd8192;
            rx_c[k] = xv[52:14];
            ry_c[k] = yv[52:14];
            tx = 40'(cx_reg[6]) + 40'(rx6_reg[k]);
            ty = 40'(cy_reg[6]) + 40'(ry6_reg[k]);
            if (tx > sqt_pkg::COORD_MAX)
                px_c[k] = 24'(sqt_pkg::COORD_MAX);
            else if (tx < sqt_pkg::COORD_MIN)
                px_c[k] = 24'(sqt_pkg::COORD_MIN);
            else
                px_c[k] = tx[23:0];
            if (ty > sqt_pkg::COORD_MAX)
                py_c[k] = 24'(sqt_pkg::COORD_MAX);
            else if (ty < sqt_pkg::COORD_MIN)
                py_c[k] = 24'(sqt_pkg::COORD_MIN);
            else
                py_c[k] = ty[23:0];
        end
    end

    always_comb
    begin
        logic signed [23:0] lx, hx, ly, hy;
        lx = px7_reg[0];
        hx = px7_reg[0];
        ly = py7_reg[0];
        hy = py7_reg[0];
        for (int k = 1; k < 4; k++)
        begin
            if (px7_reg[k] < lx) lx = px7_reg[k];
            if (px7_reg[k] > hx) hx = px7_reg[k];
            if (py7_reg[k] < ly) ly = py7_reg[k];
            if (py7_reg[k] > hy) hy = py7_reg[k];
        end
        quad_next.corner0_x  = px7_reg[0];
        quad_next.corner0_y  = py7_reg[0];
        quad_next.corner1_x  = px7_reg[1];
        quad_next.corner1_y  = py7_reg[1];
        quad_next.corner2_x  = px7_reg[2];
        quad_next.corner2_y  = py7_reg[2];
        quad_next.corner3_x  = px7_reg[3];
        quad_next.corner3_y  = py7_reg[3];
        quad_next.box_left   = lx;
        quad_next.box_top    = ly;
        quad_next.box_right  = hx;
        quad_next.box_bottom = hy;
    end

    always_ff @(posedge clk)
    begin
        cx_reg[1] <= sprite.center_x;
        cy_reg[1] <= sprite.center_y;
        for (int i = 2; i <= 7; i++)
        begin
            cx_reg[i] <= cx_reg[i-1];
            cy_reg[i] <= cy_reg[i-1];
        end
        sx1_reg <= sprite.scale_x;
        sy1_reg <= sprite.scale_y;
        pw1_reg <= width_reg * sprite.uniform_scale;
        ph1_reg <= height_reg * sprite.uniform_scale;
        // half extent, rounded and halved in one step
        hw_reg[2] <= hw_sum[43:9];
        hh_reg[2] <= hh_sum[43:9];
        hw_reg[3] <= hw_reg[2];
        hh_reg[3] <= hh_reg[2];
        hw_reg[4] <= hw_reg[3];
        hh_reg[4] <= hh_reg[3];
        p_hwc_reg <= $signed({1'b0, hw_reg[4]}) * cos_w;
        p_hhs_reg <= $signed({1'b0, hh_reg[4]}) * sin_w;
        p_hws_reg <= $signed({1'b0, hw_reg[4]}) * sin_w;
        p_hhc_reg <= $signed({1'b0, hh_reg[4]}) * cos_w;
        for (int k = 0; k < 4; k++)
        begin
            rx6_reg[k] <= rx_c[k];
            ry6_reg[k] <= ry_c[k];
            px7_reg[k] <= px_c[k];
            py7_reg[k] <= py_c[k];
        end
        quad_reg <= quad_next;
    end

    assign done = v_reg[7];
    assign quad = quad_reg;

    a_box_x_order: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (quad.box_left <= quad.box_right) && (quad.box_top <= quad.box_bottom))
        else $error("box corners out of order");

    a_box_holds_corner0: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (quad.box_left <= quad.corner0_x) && (quad.box_right >= quad.corner0_x)
              && (quad.box_top <= quad.corner0_y) && (quad.box_bottom >= quad.corner0_y))
        else $error("corner0 outside box");

    a_box_holds_corner3: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (quad.box_left <= quad.corner3_x) && (quad.box_right >= quad.corner3_x)
              && (quad.box_top <= quad.corner3_y) && (quad.box_bottom >= quad.corner3_y))
        else $error("corner3 outside box");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(v_reg[0], 7))
        else $error("result without accepted word");

endmodule

// ===== hw/rtl/sqt_sine.sv =====
module sqt_sine (
    input  logic                      clk,
    input  logic [sqt_pkg::AngW-1:0]  angle,
    output logic signed [15:0]        sin_q14,
    output logic signed [15:0]        cos_q14
);

    logic [sqt_pkg::AngW-1:0] ang_lane [2];
    logic [14:0] mag_c [2];
    logic        neg_c [2];
    logic [14:0] x2_c [2];
    logic [15:0] inner_c [2];
    logic [16:0] mid_c [2];
    logic signed [15:0] val_c [2];

    logic [14:0] mag1_reg [2];
    logic        neg1_reg [2];
    logic [14:0] x21_reg [2];
    logic [14:0] mag2_reg [2];
    logic        neg2_reg [2];
    logic [14:0] x22_reg [2];
    logic [15:0] inner2_reg [2];
    logic [14:0] mag3_reg [2];
    logic        neg3_reg [2];
    logic [16:0] mid3_reg [2];
    logic signed [15:0] val4_reg [2];

    assign ang_lane[0] = angle;
    assign ang_lane[1] = angle + sqt_pkg::QUARTER_TURN;

    always_comb
    begin
        logic signed [16:0] s;
        logic [29:0] sq;
        logic [27:0] xc;
        logic [30:0] xi;
        logic [31:0] mm;
        for (int i = 0; i < 2; i++)
        begin
            // fold into [-quarter, +quarter]
            s = {ang_lane[i][15], ang_lane[i]};
            if (s > 17'sd16384)
                s = 17'sd32768 - s;
            else if (s < -17'sd16384)
                s = -17'sd32768 - s;
            neg_c[i] = s[16];
            mag_c[i] = s[16] ? 15'(-s) : s[14:0];
            sq = mag_c[i] * mag_c[i];
            x2_c[i] = sq[28:14];
            xc = x21_reg[i] * sqt_pkg::SIN_C;
            inner_c[i] = sqt_pkg::SIN_B - 16'(xc[27:14]);
            xi = x22_reg[i] * inner2_reg[i];
            mid_c[i] = sqt_pkg::SIN_A - 17'(xi[30:14]);
            mm = mag3_reg[i] * mid3_reg[i];
            val_c[i] = neg3_reg[i] ? -$signed({1'b0, mm[30:16]})
                                   : $signed({1'b0, mm[30:16]});
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            mag1_reg[i]   <= mag_c[i];
            neg1_reg[i]   <= neg_c[i];
            x21_reg[i]    <= x2_c[i];
            mag2_reg[i]   <= mag1_reg[i];
            neg2_reg[i]   <= neg1_reg[i];
            x22_reg[i]    <= x21_reg[i];
            inner2_reg[i] <= inner_c[i];
            mag3_reg[i]   <= mag2_reg[i];
            neg3_reg[i]   <= neg2_reg[i];
            mid3_reg[i]   <= mid_c[i];
            val4_reg[i]   <= val_c[i];
        end
    end

    assign sin_q14 = val4_reg[0];
    assign cos_q14 = val4_reg[1];

endmodule

// ===== dv/sqt_checker.sv =====
`timescale 1ns / 100ps

module sqt_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  sqt_pkg::sqt_in_t   sprite,
    input  logic               done,
    input  sqt_pkg::sqt_out_t  quad,
    input  logic               cfg_we,
    input  logic [sqt_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [sqt_pkg::DimW-1:0]    cfg_data,
    output int                 fail_count,
    output int                 pending
);
    import sqt_pkg::*;

    logic [DimW-1:0] width_q;
    logic [DimW-1:0] height_q;
    sqt_out_t        quad_q[$];

    function automatic longint sine14(logic [15:0] ang);
        longint s;
        longint mag;
        longint x2;
        longint inner;
        longint mid;
        longint res;
        s = longint'(ang);
        if (s >= 32768) s -= 65536;
        if (s > 16384) s = 32768 - s;
        else if (s < -16384) s = -32768 - s;
        mag = (s < 0) ? -s : s;
        x2 = (mag * mag) >>> 14;
        inner = 42048 - ((x2 * 4640) >>> 14);
        mid = 102944 - ((x2 * inner) >>> 14);
        res = (mag * mid) >>> 16;
        return (s < 0) ? -res : res;
    endfunction

    function automatic longint sat_coord(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic sqt_out_t transform_quad(sqt_in_t s);
        sqt_out_t q;
        longint hw;
        longint hh;
        longint sn;
        longint cs;
        longint ox;
        longint oy;
        longint px[4];
        longint py[4];
        longint lx;
        longint hx;
        longint ly;
        longint hy;
        hw = (longint'(width_q) * s.uniform_scale * s.scale_x + 256) >>> 9;
        hh = (longint'(height_q) * s.uniform_scale * s.scale_y + 256) >>> 9;
        sn = sine14(s.angle);
        cs = sine14(s.angle + 16'd16384);
        for (int k = 0; k < 4; k++)
        begin
            ox = k[1] ? hw : -hw;
            oy = k[0] ? hh : -hh;
            px[k] = sat_coord(longint'(s.center_x) + ((ox * cs - oy * sn + 8192) >>> 14));
            py[k] = sat_coord(longint'(s.center_y) + ((ox * sn + oy * cs + 8192) >>> 14));
        end
        lx = px[0]; hx = px[0]; ly = py[0]; hy = py[0];
        for (int k = 1; k < 4; k++)
        begin
            if (px[k] < lx) lx = px[k];
            if (px[k] > hx) hx = px[k];
            if (py[k] < ly) ly = py[k];
            if (py[k] > hy) hy = py[k];
        end
        q.corner0_x = 24'(px[0]); q.corner0_y = 24'(py[0]);
        q.corner1_x = 24'(px[1]); q.corner1_y = 24'(py[1]);
        q.corner2_x = 24'(px[2]); q.corner2_y = 24'(py[2]);
        q.corner3_x = 24'(px[3]); q.corner3_y = 24'(py[3]);
        q.box_left = 24'(lx); q.box_top = 24'(ly);
        q.box_right = 24'(hx); q.box_bottom = 24'(hy);
        return q;
    endfunction

    task automatic cmp(string name, logic [23:0] e, logic [23:0] a);
        if (e !== a)
        begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name,
                     $signed(e), $signed(a));
            fail_count++;
        end
    endtask

    assign pending = quad_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        sqt_out_t e;
        if (!rst_n)
        begin
            width_q <= '0;
            height_q <= '0;
            fail_count = 0;
        end
        else
        begin
            if (start && !busy) quad_q.push_back(transform_quad(sprite));
            if (done)
            begin
                if (quad_q.size() == 0)
                begin
                    $display("%0t unexpected word on quad: %h", $time, quad);
                    fail_count++;
                end
                else
                begin
                    e = quad_q.pop_front();
                    cmp("corner0_x", e.corner0_x, quad.corner0_x);
                    cmp("corner0_y", e.corner0_y, quad.corner0_y);
                    cmp("corner1_x", e.corner1_x, quad.corner1_x);
                    cmp("corner1_y", e.corner1_y, quad.corner1_y);
                    cmp("corner2_x", e.corner2_x, quad.corner2_x);
                    cmp("corner2_y", e.corner2_y, quad.corner2_y);
                    cmp("corner3_x", e.corner3_x, quad.corner3_x);
                    cmp("corner3_y", e.corner3_y, quad.corner3_y);
                    cmp("box_left", e.box_left, quad.box_left);
                    cmp("box_top", e.box_top, quad.box_top);
                    cmp("box_right", e.box_right, quad.box_right);
                    cmp("box_bottom", e.box_bottom, quad.box_bottom);
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_WIDTH) width_q <= cfg_data;
                else if (cfg_index == CFG_HEIGHT) height_q <= cfg_data;
            end
        end
    end
endmodule

// ===== dv/sprite_quad_transform_tb.sv =====
`timescale 1ns / 100ps

module sprite_quad_transform_tb;
    import sqt_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    sqt_in_t sprite = '0;
    logic done;
    sqt_out_t quad;
    logic cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [DimW-1:0] cfg_data = '0;
    int fail_count;
    int pending;
    int idle_cycles = 0;
    int words_sent = 0;
    int words_done = 0;

    always #5 clk = ~clk;

    sprite_quad_transform i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sprite(sprite),
        .done(done), .quad(quad), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    sqt_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sprite(sprite),
        .done(done), .quad(quad), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
    );

    always @(posedge clk)
    begin
        if (done) words_done++;
        if ((start && !busy) || done) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("timeout");
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [15:0] rand_scale();
        case ($urandom_range(0, 5))
            0: return 16'h0100;
            1: return 16'hFFFF;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 1023));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return 24'(24'h7FFFFF - $urandom_range(0, 4095));
            1: return 24'(24'h800000 + $urandom_range(0, 4095));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_sprite(sqt_in_t s);
        sprite <= s;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        words_sent++;
    endtask

    task automatic pause_line();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_size(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_run(int n);
        sqt_in_t s;
        for (int i = 0; i < n; i++)
        begin
            s.center_x = rand_coord();
            s.center_y = rand_coord();
            s.angle = ($urandom_range(0, 7) == 0) ? 16'(($urandom_range(0, 7)) * 8192)
                                                : 16'($urandom);
            s.uniform_scale = rand_scale();
            s.scale_x = rand_scale();
            s.scale_y = rand_scale();
            send_sprite(s);
            if ($urandom_range(0, 3) == 0 && (i % 100) > 30) pause_line();
        end
    endtask

    initial
    begin
        sqt_in_t s;
        logic [15:0] angles[8];
        logic [DimW-1:0] widths[5];
        logic [DimW-1:0] heights[5];
        angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000, 16'hFFFF,
                   16'h4001, 16'hBFFF};
        widths = '{12'd16, 12'd4095, 12'd0, 12'd1, 12'd0};
        heights = '{12'd9, 12'd4095, 12'd0, 12'd4095, 12'd1};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_size(CFG_WIDTH, 12'd64);
        write_size(CFG_HEIGHT, 12'd32);
        write_size(CfgUnused, 12'hFFF);
        for (int i = 0; i < 8; i++)
        begin
            s.center_x = 24'sd12800;
            s.center_y = -24'sd6400;
            s.angle = angles[i];
            s.uniform_scale = 16'h0100;
            s.scale_x = 16'h0180;
            s.scale_y = 16'h0080;
            send_sprite(s);
        end
        s = '{24'h7FFFFF, 24'h7FFFFF, 16'h2000, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        send_sprite(s);
        s = '{24'h800000, 24'h800000, 16'hA000, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        send_sprite(s);
        s = '{24'h123456, 24'hABCDEF, 16'h1234, 16'h0000, 16'h0100, 16'h0100};
        send_sprite(s);
        s = '{24'h000000, 24'h000000, 16'h0000, 16'h0100, 16'h0000, 16'h0000};
        send_sprite(s);
        drain();

        for (int p = 0; p < 5; p++)
        begin
            write_size(CFG_WIDTH, widths[p]);
            write_size(CFG_HEIGHT, heights[p]);
            if (p == 3) write_size(CfgUnused, 12'h5A5);
            random_run(p == 4 ? 180 : 200);
            drain();
        end

        $display("%0d sprites sent, %0d quads checked over six size settings incl. 0 and 4095",
                 words_sent, words_done);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ===== sprite_quad_transform.f =====
hw/rtl/sqt_pkg.sv
hw/rtl/sqt_sine.sv
hw/rtl/sprite_quad_transform.sv
dv/sqt_checker.sv
dv/sprite_quad_transform_tb.sv
